>>> hw/rtl/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> hw/rtl/i2cebm_pkg.sv
package i2cebm_pkg;
    localparam int unsigned QueueDepth = 2;
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic [1:0] REG_WIDE = 2'd0;
    localparam logic [1:0] REG_HALF = 2'd1;
    localparam logic [1:0] REG_ACKT = 2'd2;
    localparam logic [1:0] REG_WAIT = 2'd3;
    localparam logic [7:0] DEV_WR = 8'hA0;
    localparam logic [7:0] DEV_RD = 8'hA1;
    localparam logic [15:0] HALF_RST = 16'd30;
    localparam logic [7:0]  ACKT_RST = 8'd250;
    localparam logic [15:0] WAIT_RST = 16'd500;

    // one classified tick
    typedef struct packed {
        logic        start;
        logic        is_read;
        logic [15:0] mem_address;
        logic [7:0]  write_data;
        logic        sda_in;
    } t_tick;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_error;
    } t_res;

    typedef struct packed {
        logic        wide;
        logic [15:0] half;
        logic [7:0]  ackt;
        logic [15:0] wwait;
    } t_cfg;
endpackage

>>> hw/rtl/i2c_eeprom_byte_master_top.sv
// channel  | handshake        | payload
// input    | push / full      | i_cmd, i_mem_address, i_write_data, i_sda_in
// result   | empty / pop      | o_scl_level .. o_ack_error
// config   | i_cfg_we         | i_cfg_index, i_cfg_data
// one tick per cycle: the front queues ticks, the sequencer takes one per cycle
// and writes its result into a two-entry result queue in the same cycle.
// the sequencer stalls while the tick queue is empty or the result queue is full; full then backs up.
// reset (synchronous, active low) empties both queues and idles the bus.
module i2c_eeprom_byte_master_top #(
    parameter int unsigned QDepth = i2cebm_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_mem_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_sda_in,
    output logic        empty,
    input  logic        pop,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_data,
    output logic        o_ack_error,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import i2cebm_pkg::*;
    `include "assert_macros.svh"

    t_tick tick_in, tick_q;
    t_res res, res_q;
    t_cfg r_cfg;
    logic tq_full, tq_empty, rq_full, step;

    // front classification and tick queue
    i2cebm_front u_front (
        .i_cmd_valid(1'b1), .i_cmd(i_cmd), .i_mem_address(i_mem_address),
        .i_write_data(i_write_data), .i_sda_in(i_sda_in), .o_tick(tick_in)
    );
    i2cebm_fifo #(.Width($bits(t_tick)), .Depth(QDepth)) u_tq (
        .i_clk, .i_rst_n, .i_push(push), .i_data(tick_in), .o_full(tq_full),
        .i_pop(step), .o_data(tick_q), .o_empty(tq_empty)
    );
    assign full = tq_full;
    assign step = !tq_empty && !rq_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{wide: 1'b0, half: HALF_RST, ackt: ACKT_RST, wwait: WAIT_RST};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIDE: r_cfg.wide  <= i_cfg_data[0];
                REG_HALF: r_cfg.half  <= i_cfg_data;
                REG_ACKT: r_cfg.ackt  <= i_cfg_data[7:0];
                REG_WAIT: r_cfg.wwait <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // bus sequencer
    i2cebm_engine u_engine (
        .i_clk, .i_rst_n, .i_valid(step), .i_tick(tick_q), .i_cfg(r_cfg), .o_res(res)
    );

    // result queue
    i2cebm_fifo #(.Width($bits(t_res)), .Depth(QDepth)) u_rq (
        .i_clk, .i_rst_n, .i_push(step), .i_data(res), .o_full(rq_full),
        .i_pop(pop), .o_data(res_q), .o_empty(empty)
    );
    assign o_scl_level = res_q.scl_level;
    assign o_sda_level = res_q.sda_level;
    assign o_busy_res  = res_q.busy_res;
    assign o_done_res  = res_q.done_res;
    assign o_read_data = res_q.read_data;
    assign o_ack_error = res_q.ack_error;

    `ASSERT_NEVER(a_step_full, i_clk, i_rst_n, step && rq_full, "step into full result queue")
    `ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, (step && res.done_res) |-> !res.busy_res, "done busy")
    `ASSERT_IMPL(a_no_step_empty, i_clk, i_rst_n, tq_empty |-> !step, "step with no tick")
endmodule

>>> hw/rtl/i2cebm_fifo.sv
module i2cebm_fifo #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [Width-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [Width-1:0] o_data,
    output logic             o_empty
);
    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
    logic [Width-1:0] r_mem [Depth];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0] r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(Depth));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == AW'(Depth-1)) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == AW'(Depth-1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end
endmodule

>>> hw/rtl/i2cebm_front.sv
module i2cebm_front (
    input  logic                i_cmd_valid,
    input  logic [1:0]          i_cmd,
    input  logic [15:0]         i_mem_address,
    input  logic [7:0]          i_write_data,
    input  logic                i_sda_in,
    output i2cebm_pkg::t_tick   o_tick
);
    import i2cebm_pkg::*;
    // classify the command
    always_comb begin
        o_tick.start       = i_cmd_valid && (i_cmd == CMD_WRITE || i_cmd == CMD_READ);
        o_tick.is_read     = (i_cmd == CMD_READ);
        o_tick.mem_address = i_mem_address;
        o_tick.write_data  = i_write_data;
        o_tick.sda_in      = i_sda_in;
    end
endmodule

>>> hw/rtl/i2cebm_engine.sv
module i2cebm_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  i2cebm_pkg::t_tick  i_tick,
    input  i2cebm_pkg::t_cfg   i_cfg,
    output i2cebm_pkg::t_res   o_res
);
    import i2cebm_pkg::*;
    localparam logic [4:0] PH_IDLE=5'd0, PH_ST_A=5'd1, PH_ST_B=5'd2, PH_TX_LO=5'd3,
        PH_TX_HI=5'd4, PH_TX_LO2=5'd5, PH_AK_LO=5'd6, PH_AK_HI=5'd7, PH_AK_POLL=5'd8,
        PH_RX_LO=5'd9, PH_RX_HI=5'd10, PH_NK_LO=5'd11, PH_NK_HI=5'd12, PH_SP_A=5'd13,
        PH_SP_B=5'd14, PH_SP_C=5'd15, PH_WW=5'd16;
    localparam logic [2:0] SG_DEV=3'd0, SG_HIGH=3'd1, SG_LOW=3'd2, SG_DATA=3'd3,
        SG_RDEV=3'd4;

    logic [4:0] r_phase, n_phase;
    logic [3:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic [15:0] r_tick, n_tick;
    logic [7:0] r_poll, n_poll;
    logic [15:0] r_addr, n_addr;
    logic [7:0] r_data, n_data;
    logic r_rd, n_rd, r_scl, n_scl, r_sda, n_sda;
    logic [2:0] r_stage, n_stage;
    logic [7:0] r_last, n_last;
    logic r_err, n_err, done;
    logic over;
    logic [15:0] tick_inc;
    logic [7:0] tx_byte;
    logic [2:0] tx_stage;
    logic do_tx;

    assign tick_inc = r_tick + 16'd1;
    assign over = (tick_inc >= i_cfg.half);

    // byte for the stage being sent
    always_comb begin
        unique case (tx_stage)
            SG_DEV:  tx_byte = i_cfg.wide ? DEV_WR : (DEV_WR | {4'd0, r_addr[10:8], 1'b0});
            SG_HIGH: tx_byte = r_addr[15:8];
            SG_LOW:  tx_byte = r_addr[7:0];
            SG_DATA: tx_byte = r_data;
            default: tx_byte = DEV_RD;
        endcase
    end

    // sequencer
    always_comb begin
        n_phase=r_phase; n_bit=r_bit; n_shift=r_shift; n_poll=r_poll;
        n_addr=r_addr; n_data=r_data; n_rd=r_rd; n_scl=r_scl; n_sda=r_sda;
        n_stage=r_stage; n_last=r_last; n_err=r_err; done=1'b0;
        n_tick = over ? 16'd0 : tick_inc;
        tx_stage = r_stage; do_tx = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                n_tick = r_tick;
                if (i_tick.start) begin
                    n_addr=i_tick.mem_address; n_data=i_tick.write_data;
                    n_rd=i_tick.is_read; n_err=1'b0; n_poll='0; n_bit='0;
                    n_stage=SG_DEV; n_phase=PH_ST_A; n_scl=1'b1; n_sda=1'b1; n_tick='0;
                end
            end
            PH_ST_A: if (over) begin n_phase=PH_ST_B; n_scl=1'b1; n_sda=1'b0; end
            PH_ST_B: if (over) do_tx = 1'b1;
            PH_TX_LO: if (over) begin n_phase=PH_TX_HI; n_scl=1'b1; end
            PH_TX_HI: if (over) begin n_phase=PH_TX_LO2; n_scl=1'b0; end
            PH_TX_LO2: if (over) begin
                n_bit = r_bit + 4'd1;
                if (n_bit < 4'd8) begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_phase=PH_TX_LO; n_scl=1'b0; n_sda=r_shift[6];
                end else begin
                    n_phase=PH_AK_LO; n_scl=1'b0; n_sda=1'b1;
                end
            end
            PH_AK_LO: if (over) begin n_phase=PH_AK_HI; n_scl=1'b1; n_sda=1'b1; end
            PH_AK_HI: if (over) begin n_poll='0; n_phase=PH_AK_POLL; end
            PH_AK_POLL: begin
                n_tick = r_tick;
                if (!i_tick.sda_in) begin
                    n_poll = '0; n_tick = '0;
                    unique case (r_stage)
                        SG_DEV: begin
                            n_stage = i_cfg.wide ? SG_HIGH : SG_LOW;
                            tx_stage = n_stage; do_tx = 1'b1;
                        end
                        SG_HIGH: begin n_stage=SG_LOW; tx_stage=SG_LOW; do_tx=1'b1; end
                        SG_LOW: if (r_rd) begin
                            n_stage=SG_RDEV; n_phase=PH_ST_A; n_scl=1'b1; n_sda=1'b1;
                        end else begin
                            n_stage=SG_DATA; tx_stage=SG_DATA; do_tx=1'b1;
                        end
                        SG_DATA: begin n_phase=PH_SP_A; n_scl=1'b0; n_sda=1'b0; end
                        default: begin
                            n_bit='0; n_shift='0; n_phase=PH_RX_LO; n_scl=1'b0; n_sda=1'b1;
                        end
                    endcase
                end else if (r_poll >= i_cfg.ackt) begin
                    n_err=1'b1; n_poll='0; n_tick='0;
                    n_phase=PH_SP_A; n_scl=1'b0; n_sda=1'b0;
                end else begin
                    n_poll = r_poll + 8'd1;
                end
            end
            PH_RX_LO: if (over) begin n_phase=PH_RX_HI; n_scl=1'b1; n_sda=1'b1; end
            PH_RX_HI: if (over) begin
                n_shift = {r_shift[6:0], i_tick.sda_in};
                n_bit = r_bit + 4'd1;
                n_phase = (n_bit < 4'd8) ? PH_RX_LO : PH_NK_LO;
                n_scl=1'b0; n_sda=1'b1;
            end
            PH_NK_LO: if (over) begin n_phase=PH_NK_HI; n_scl=1'b1; n_sda=1'b1; end
            PH_NK_HI: if (over) begin
                n_last=r_shift; n_phase=PH_SP_A; n_scl=1'b0; n_sda=1'b0;
            end
            PH_SP_A: if (over) begin n_phase=PH_SP_B; n_scl=1'b1; n_sda=1'b0; end
            PH_SP_B: if (over) begin n_phase=PH_SP_C; n_scl=1'b1; n_sda=1'b1; end
            PH_SP_C: if (over) begin
                n_scl=1'b1; n_sda=1'b1;
                if (!r_err && !r_rd && i_cfg.wwait != 16'd0) n_phase=PH_WW;
                else begin n_phase=PH_IDLE; done=1'b1; end
            end
            PH_WW: begin
                n_tick = tick_inc;
                if (tick_inc >= i_cfg.wwait) begin
                    n_phase=PH_IDLE; n_tick='0; done=1'b1;
                end
            end
            default: begin n_phase=PH_IDLE; n_scl=1'b1; n_sda=1'b1; n_tick='0; end
        endcase
        if (do_tx) begin
            n_shift=tx_byte; n_bit='0; n_phase=PH_TX_LO; n_scl=1'b0;
            n_sda=tx_byte[7]; n_tick='0;
        end
    end

    // state registers, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase<=PH_IDLE; r_bit<='0; r_shift<='0; r_tick<='0; r_poll<='0;
            r_addr<='0; r_data<='0; r_rd<=1'b0; r_scl<=1'b1; r_sda<=1'b1;
            r_stage<=SG_DEV; r_last<='0; r_err<=1'b0;
        end else if (i_valid) begin
            r_phase<=n_phase; r_bit<=n_bit; r_shift<=n_shift; r_tick<=n_tick;
            r_poll<=n_poll; r_addr<=n_addr; r_data<=n_data; r_rd<=n_rd;
            r_scl<=n_scl; r_sda<=n_sda; r_stage<=n_stage; r_last<=n_last; r_err<=n_err;
        end
    end

    assign o_res = '{scl_level: n_scl, sda_level: n_sda, busy_res: (n_phase != PH_IDLE),
                     done_res: done, read_data: n_last, ack_error: n_err};
endmodule
